/* hw/rtl/auvf_pkg.sv */
// shared types and constants for the angle unwrap and velocity filter
`timescale 1ns / 1ps

package auvf_pkg;

    localparam int ACC_W     = 64;
    localparam int OPB_W     = 26;
    localparam int VAL_W     = 48;
    localparam int MUL_STEPS = 20;
    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic start;
        logic div;
    } auvf_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } auvf_sts_t;

    localparam logic [1:0] CFG_CPR    = 2'd0;
    localparam logic [1:0] CFG_INVERT = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;
    localparam logic [1:0] CFG_UNITS  = 2'd3;

    localparam logic [1:0] UNITS_DEG = 2'd0;
    localparam logic [1:0] UNITS_RAD = 2'd1;
    localparam logic [1:0] UNITS_ROT = 2'd2;

    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [15:0] TWO_PI_Q13 = 16'd51472;

    localparam logic [12:0] CPR_RESET   = 13'd4096;
    localparam logic [16:0] ALPHA_UNITY = 17'h10000;

    localparam logic [VAL_W-1:0] MAX48  = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] MIN48  = 48'h8000_0000_0000;

    // scale factor of a unit, counts per revolution divide it
    function automatic logic [15:0] unit_mult(input logic [1:0] units);
        logic [15:0] m;
        case (units)
            UNITS_DEG: m = 16'd360;
            UNITS_RAD: m = TWO_PI_Q13;
            UNITS_ROT: m = 16'd1;
            default:   m = 16'd0;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] unit_shift(input logic [1:0] units);
        logic [3:0] s;
        case (units)
            UNITS_RAD: s = 4'd13;
            default:   s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/auvf_muldiv.sv */
// shared iterative unit: shift-add multiply and restoring divide on one adder
`timescale 1ns / 1ps

module auvf_muldiv (
    input  logic                     clk,
    input  logic                     rst_n,
    input  auvf_pkg::auvf_cmd_t      cmd,
    input  logic [auvf_pkg::ACC_W-1:0] opa,
    input  logic [auvf_pkg::OPB_W-1:0] opb,
    input  logic [auvf_pkg::ACC_W-1:0] opc,
    output auvf_pkg::auvf_sts_t      sts,
    output logic [auvf_pkg::ACC_W-1:0] result
);
    import auvf_pkg::*;

    localparam logic [5:0] MUL_LAST = 6'(MUL_STEPS - 1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

    logic             busy_reg;
    logic             done_reg;
    logic             div_reg;
    logic [5:0]       cnt_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] mcand_reg;
    logic [OPB_W-1:0] b_reg;
    logic [OPB_W-1:0] rem_reg;

    logic [OPB_W:0]   rem_sh;
    logic [ACC_W:0]   add_x;
    logic [ACC_W:0]   add_y;
    logic [ACC_W:0]   add_sum;

    // divide: remainder minus divisor, bit 64 set means it went negative
    assign rem_sh  = {rem_reg, acc_reg[ACC_W-1]};
    assign add_x   = div_reg ? (ACC_W + 1)'(rem_sh) : {1'b0, acc_reg};
    assign add_y   = div_reg ? ~((ACC_W + 1)'(b_reg)) : {1'b0, mcand_reg};
    assign add_sum = add_x + add_y + (ACC_W + 1)'(div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                div_reg  <= cmd.div;
                cnt_reg  <= cmd.div ? DIV_LAST : MUL_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg   <= cmd.div ? opa : opc;
            mcand_reg <= opa;
            b_reg     <= opb;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!add_sum[ACC_W])
                begin
                    rem_reg <= add_sum[OPB_W-1:0];
                    acc_reg <= {acc_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[OPB_W-1:0];
                    acc_reg <= {acc_reg[ACC_W-2:0], 1'b0};
                end
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= add_sum[ACC_W-1:0];
                end
                mcand_reg <= {mcand_reg[ACC_W-2:0], 1'b0};
                b_reg     <= {1'b0, b_reg[OPB_W-1:1]};
            end
        end
    end

    assign sts    = '{busy: busy_reg, done: done_reg};
    assign result = acc_reg;

endmodule

/* hw/rtl/angle_unwrap_velocity_filter.sv */
// top level: angle unwrap, turn count, smoothed velocity and unit conversion
// flow: one item at a time; the input is stalled until the block is idle again;
// the 64-step divider runs three times per sample item, beside the 20-step multiplier
// reset: configuration to its defaults, angle, turn count and velocity to zero
`timescale 1ns / 1ps

module angle_unwrap_velocity_filter #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [ANGLE_BITS-1:0] raw_angle,
    input  logic [19:0]           interval_us,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [47:0]    angle_value,
    output logic signed [47:0]    velocity_value,
    output logic                  count_saturated,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [16:0]           cfg_data
);
    import auvf_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_STEP = 5'd1;
    localparam logic [4:0] S_TURN = 5'd2;
    localparam logic [4:0] S_M1L  = 5'd3;
    localparam logic [4:0] S_M1W  = 5'd4;
    localparam logic [4:0] S_D1L  = 5'd5;
    localparam logic [4:0] S_D1W  = 5'd6;
    localparam logic [4:0] S_INST = 5'd7;
    localparam logic [4:0] S_DIFF = 5'd8;
    localparam logic [4:0] S_EABS = 5'd9;
    localparam logic [4:0] S_EML  = 5'd10;
    localparam logic [4:0] S_EMW  = 5'd11;
    localparam logic [4:0] S_EMA  = 5'd12;
    localparam logic [4:0] S_CABS = 5'd13;
    localparam logic [4:0] S_CML  = 5'd14;
    localparam logic [4:0] S_CMW  = 5'd15;
    localparam logic [4:0] S_CDL  = 5'd16;
    localparam logic [4:0] S_CDW  = 5'd17;
    localparam logic [4:0] S_CNEG = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    logic [4:0]             state_reg;

    logic [12:0]            cpr_reg;
    logic                   invert_reg;
    logic [16:0]            alpha_reg;
    logic [1:0]             units_reg;

    logic [ANGLE_BITS-1:0]  prev_reg;
    logic signed [31:0]     tc_reg;
    logic signed [47:0]     vel_reg;
    logic                   flag_reg;
    logic                   sel_reg;

    logic [ANGLE_BITS-1:0]  raw_in_reg;
    logic [19:0]            dt_reg;
    logic signed [17:0]     d_reg;
    logic [16:0]            dabs_reg;
    logic                   delta_neg_reg;
    logic [47:0]            q_mag_reg;
    logic                   q_neg_reg;
    logic signed [47:0]     inst_reg;
    logic signed [48:0]     diff_reg;
    logic                   diff_neg_reg;
    logic [47:0]            step_reg;
    logic                   xneg_reg;
    logic [47:0]            angle_res_reg;
    logic [47:0]            vel_res_reg;

    logic                   out_valid_reg;
    logic [47:0]            angle_out_reg;
    logic [47:0]            vel_out_reg;
    logic                   sat_out_reg;

    logic [ACC_W-1:0]       opa_reg;
    logic [OPB_W-1:0]       opb_reg;
    logic [ACC_W-1:0]       opc_reg;

    auvf_cmd_t              cmd;
    auvf_sts_t              sts;
    logic [ACC_W-1:0]       unit_result;

    logic                   in_accept;
    logic                   out_free;

    logic [12:0]            cpr_used;
    logic [16:0]            alpha_used;
    logic [OPB_W-1:0]       den;

    logic [15:0]            wrap_diff;
    logic signed [17:0]     d_ext;
    logic signed [17:0]     cpr_s;
    logic signed [17:0]     half_s;
    logic signed [17:0]     fold_a;
    logic signed [17:0]     fold_b;
    logic [16:0]            fold_abs;

    logic signed [33:0]     turn_sum;
    logic                   turn_ovf;
    logic                   sat_hi;
    logic                   sat_lo;
    logic [31:0]            room_hi;
    logic [31:0]            room_lo;
    logic [16:0]            delta_mag;

    logic [48:0]            diff_abs;
    logic signed [49:0]     vsum;
    logic [31:0]            tc_abs;
    logic [47:0]            vel_abs;
    logic [47:0]            x_abs;
    logic                   x_neg;
    logic [47:0]            conv_res;

    function automatic logic [47:0] clamp_mag(input logic [ACC_W-1:0] q,
                                              input logic allow_min);
        logic [47:0] lim;
        lim = allow_min ? MIN48 : MAX48;
        return (q > ACC_W'(lim)) ? lim : q[47:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign cpr_used   = (cpr_reg < 13'd2) ? 13'd2 : cpr_reg;
    assign alpha_used = (alpha_reg > ALPHA_UNITY) ? ALPHA_UNITY : alpha_reg;
    assign den        = OPB_W'(cpr_used) << unit_shift(units_reg);

    // step folded once by a revolution toward zero
    assign wrap_diff = 16'(raw_in_reg) - 16'(prev_reg);
    assign d_ext     = 18'(signed'(wrap_diff));
    assign cpr_s     = signed'(18'(cpr_used));
    assign half_s    = signed'(18'(cpr_used >> 1));
    assign fold_a    = (d_ext > half_s) ? d_ext - cpr_s : d_ext;
    assign fold_b    = (fold_a < -half_s) ? fold_a + cpr_s : fold_a;
    assign fold_abs  = fold_b[17] ? 17'(-fold_b) : 17'(fold_b);

    // turn count with saturation; the applied change is what drives velocity
    assign turn_sum  = 34'(tc_reg) + 34'(d_reg);
    assign turn_ovf  = (turn_sum[33:31] != 3'b000) && (turn_sum[33:31] != 3'b111);
    assign sat_hi    = turn_ovf && !turn_sum[33];
    assign sat_lo    = turn_ovf && turn_sum[33];
    assign room_hi   = 32'h7FFF_FFFF - 32'(tc_reg);
    assign room_lo   = 32'(tc_reg) - 32'h8000_0000;
    assign delta_mag = sat_hi ? 17'(room_hi) : (sat_lo ? 17'(room_lo) : dabs_reg);

    assign diff_abs = diff_reg[48] ? 49'(-diff_reg) : 49'(diff_reg);
    assign vsum     = diff_neg_reg ? 50'(vel_reg) - signed'(50'(step_reg))
                                   : 50'(vel_reg) + signed'(50'(step_reg));

    assign tc_abs   = tc_reg[31] ? 32'(-tc_reg) : 32'(tc_reg);
    assign vel_abs  = vel_reg[47] ? 48'(-vel_reg) : 48'(vel_reg);
    assign x_abs    = sel_reg ? vel_abs : {tc_abs, 16'b0};
    assign x_neg    = sel_reg ? vel_reg[47] : tc_reg[31];
    assign conv_res = q_neg_reg ? 48'(-q_mag_reg) : q_mag_reg;

    assign cmd.start = (state_reg == S_M1L) || (state_reg == S_D1L) ||
                       (state_reg == S_EML) || (state_reg == S_CML) ||
                       (state_reg == S_CDL);
    assign cmd.div   = (state_reg == S_D1L) || (state_reg == S_CDL);

    auvf_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .opc    (opc_reg),
        .sts    (sts),
        .result (unit_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg    <= CPR_RESET;
            invert_reg <= 1'b0;
            alpha_reg  <= ALPHA_UNITY;
            units_reg  <= UNITS_DEG;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CPR:    cpr_reg    <= cfg_data[12:0];
                CFG_INVERT: invert_reg <= cfg_data[0];
                CFG_ALPHA:  alpha_reg  <= cfg_data;
                CFG_UNITS:  units_reg  <= cfg_data[1:0];
                default:    cpr_reg    <= cpr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            tc_reg        <= '0;
            vel_reg       <= '0;
            flag_reg      <= 1'b0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_OUT the output register is either reloaded or still held
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        flag_reg <= 1'b0;
                        sel_reg  <= 1'b0;
                        if (mode)
                        begin
                            prev_reg  <= raw_angle;
                            tc_reg    <= '0;
                            vel_reg   <= '0;
                            state_reg <= S_CABS;
                        end
                        else if (interval_us == '0)
                        begin
                            state_reg <= S_CABS;
                        end
                        else
                        begin
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_STEP:
                begin
                    prev_reg  <= raw_in_reg;
                    state_reg <= S_TURN;
                end
                S_TURN:
                begin
                    flag_reg <= turn_ovf;
                    if (sat_hi)
                    begin
                        tc_reg <= 32'sh7FFF_FFFF;
                    end
                    else if (sat_lo)
                    begin
                        tc_reg <= signed'(32'h8000_0000);
                    end
                    else
                    begin
                        tc_reg <= turn_sum[31:0];
                    end
                    state_reg <= S_M1L;
                end
                S_M1L:   state_reg <= S_M1W;
                S_M1W:
                begin
                    if (sts.done)
                    begin
                        state_reg <= S_D1L;
                    end
                end
                S_D1L:   state_reg <= S_D1W;
                S_D1W:
                begin
                    if (sts.done)
                    begin
                        state_reg <= S_INST;
                    end
                end
                S_INST:  state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_EABS;
                S_EABS:  state_reg <= S_EML;
                S_EML:   state_reg <= S_EMW;
                S_EMW:
                begin
                    if (sts.done)
                    begin
                        state_reg <= S_EMA;
                    end
                end
                S_EMA:
                begin
                    if (vsum[49:47] != 3'b000 && vsum[49:47] != 3'b111)
                    begin
                        vel_reg <= vsum[49] ? signed'(MIN48) : signed'(MAX48);
                    end
                    else
                    begin
                        vel_reg <= vsum[47:0];
                    end
                    sel_reg   <= 1'b0;
                    state_reg <= S_CABS;
                end
                S_CABS:
                begin
                    // unknown units report zero without a conversion pass
                    state_reg <= (units_reg == UNITS_DEG || units_reg == UNITS_RAD ||
                                  units_reg == UNITS_ROT) ? S_CML : S_CNEG;
                end
                S_CML:   state_reg <= S_CMW;
                S_CMW:
                begin
                    if (sts.done)
                    begin
                        state_reg <= S_CDL;
                    end
                end
                S_CDL:   state_reg <= S_CDW;
                S_CDW:
                begin
                    if (sts.done)
                    begin
                        state_reg <= S_CNEG;
                    end
                end
                S_CNEG:
                begin
                    if (!sel_reg)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_CABS;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                raw_in_reg <= raw_angle;
                dt_reg     <= interval_us;
            end
            S_STEP:
            begin
                d_reg    <= fold_b;
                dabs_reg <= fold_abs;
            end
            S_TURN:
            begin
                delta_neg_reg <= sat_lo || (!sat_hi && d_reg[17]);
                opa_reg       <= ACC_W'({delta_mag, 16'b0});
                opb_reg       <= OPB_W'(US_PER_S);
                opc_reg       <= ACC_W'(dt_reg >> 1);
            end
            S_M1W:
            begin
                if (sts.done)
                begin
                    opa_reg <= unit_result;
                    opb_reg <= OPB_W'(dt_reg);
                end
            end
            S_D1W:
            begin
                if (sts.done)
                begin
                    q_mag_reg <= clamp_mag(unit_result, delta_neg_reg);
                    q_neg_reg <= delta_neg_reg;
                end
            end
            S_INST:
            begin
                inst_reg <= q_neg_reg ? signed'(48'(-q_mag_reg)) : signed'(q_mag_reg);
            end
            S_DIFF:
            begin
                diff_reg <= 49'(inst_reg) - 49'(vel_reg);
            end
            S_EABS:
            begin
                // rounding half is preloaded into the accumulator
                diff_neg_reg <= diff_reg[48];
                opa_reg      <= ACC_W'(diff_abs);
                opb_reg      <= OPB_W'(alpha_used);
                opc_reg      <= ACC_W'(32768);
            end
            S_EMW:
            begin
                if (sts.done)
                begin
                    step_reg <= unit_result[63:16];
                end
            end
            S_CABS:
            begin
                xneg_reg  <= x_neg;
                opa_reg   <= ACC_W'(x_abs);
                opb_reg   <= OPB_W'(unit_mult(units_reg));
                opc_reg   <= ACC_W'(den >> 1);
                q_mag_reg <= '0;
                q_neg_reg <= 1'b0;
            end
            S_CMW:
            begin
                if (sts.done)
                begin
                    opa_reg <= unit_result;
                    opb_reg <= den;
                end
            end
            S_CDW:
            begin
                if (sts.done)
                begin
                    q_mag_reg <= clamp_mag(unit_result, xneg_reg && !invert_reg);
                    q_neg_reg <= xneg_reg ^ invert_reg;
                end
            end
            S_CNEG:
            begin
                if (!sel_reg)
                begin
                    angle_res_reg <= conv_res;
                end
                else
                begin
                    vel_res_reg <= conv_res;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    angle_out_reg <= angle_res_reg;
                    vel_out_reg   <= vel_res_reg;
                    sat_out_reg   <= flag_reg;
                end
            end
            default:
            begin
                dt_reg <= dt_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign angle_value     = signed'(angle_out_reg);
    assign velocity_value  = signed'(vel_out_reg);
    assign count_saturated = sat_out_reg;

endmodule

/* sim/tb_angle_unwrap_velocity_filter.sv */
// testbench for the angle unwrap and velocity filter, checked against a local predictor
`timescale 1ns / 1ps

module tb_angle_unwrap_velocity_filter;

    import auvf_pkg::*;

    localparam int     ANGLE_BITS = 12;
    localparam int     CYCLE_LIMIT = 1200000;
    localparam int     IDLE_PCT = 34;
    localparam int     SETTLE_CYCLES = 400;
    localparam longint V_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint V_MIN = -V_MAX - 1;
    localparam longint TURN_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint TURN_MIN = -TURN_MAX - 1;

    typedef struct packed {
        logic                  mode;
        logic [ANGLE_BITS-1:0] raw;
        logic [19:0]           dt;
    } sample_item_t;

    typedef struct packed {
        logic [47:0] angle;
        logic [47:0] velocity;
        logic        sat;
    } readout_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode = 1'b0;
    logic [ANGLE_BITS-1:0] raw_angle = '0;
    logic [19:0]           interval_us = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [47:0]    angle_value;
    logic signed [47:0]    velocity_value;
    logic                  count_saturated;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [16:0]           cfg_data = '0;

    angle_unwrap_velocity_filter #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .raw_angle      (raw_angle),
        .interval_us    (interval_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_value    (angle_value),
        .velocity_value (velocity_value),
        .count_saturated(count_saturated),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // register copies and tracked state of the unwrapper
    logic [12:0]           cfg_cpr = CPR_RESET;
    logic                  cfg_invert = 1'b0;
    logic [16:0]           cfg_alpha = ALPHA_UNITY;
    logic [1:0]            cfg_units = UNITS_DEG;
    logic [ANGLE_BITS-1:0] trk_prev_angle = '0;
    int                    trk_turns = 0;
    longint                trk_velocity = 0;

    sample_item_t pending_items[$];
    readout_t     expected_readouts[$];
    sample_item_t next_item;
    readout_t     predicted;
    readout_t     want;
    logic         in_took = 1'b0;
    int           accepted_count = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    bit           calm;

    int cpr_picks[8]    = '{4096, 2, 8191, 0, 1, 360, 1000, 4095};
    int alpha_picks[8]  = '{65536, 0, 1, 131071, 32768, 65535, 65537, 6554};
    int units_picks[8]  = '{0, 1, 2, 3, 1, 2, 0, 1};
    int invert_picks[8] = '{0, 1, 1, 0, 1, 0, 0, 1};

    function automatic longint clip48(input longint v);
        if (v > V_MAX)
            return V_MAX;
        if (v < V_MIN)
            return V_MIN;
        return v;
    endfunction

    // halves round away from zero
    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint scale_to_units(input longint xq16);
        longint          m;
        int              s;
        longint          r;
        longint unsigned den;
        case (cfg_units)
            UNITS_DEG:
            begin
                m = 360;
                s = 0;
            end
            UNITS_RAD:
            begin
                m = TWO_PI_Q13;
                s = 13;
            end
            UNITS_ROT:
            begin
                m = 1;
                s = 0;
            end
            default:   return 0;
        endcase
        den = longint'((cfg_cpr < 2) ? 2 : cfg_cpr) << s;
        r = clip48(round_div(xq16 * m, den));
        if (cfg_invert)
            r = (r == V_MIN) ? V_MAX : -r;
        return r;
    endfunction

    task automatic track_item(input sample_item_t it, output readout_t r);
        int              eff_cpr;
        int              half;
        int              d;
        logic [15:0]     w;
        longint          sum;
        longint          delta;
        longint          inst;
        longint          diff;
        longint          conv;
        logic [63:0]     mag;
        logic [63:0]     stepm;
        longint unsigned alpha;
        bit              neg;
        r.sat = 1'b0;
        if (it.mode)
        begin
            trk_prev_angle = it.raw;
            trk_turns = 0;
            trk_velocity = 0;
        end
        else if (it.dt != 0)
        begin
            eff_cpr = (cfg_cpr < 2) ? 2 : int'(cfg_cpr);
            half = eff_cpr / 2;
            w = {4'b0, it.raw} - {4'b0, trk_prev_angle};
            d = $signed(w);
            if (d > half)
                d = d - eff_cpr;
            if (d < -half)
                d = d + eff_cpr;
            trk_prev_angle = it.raw;
            sum = longint'(trk_turns) + d;
            if (sum > TURN_MAX)
            begin
                sum = TURN_MAX;
                r.sat = 1'b1;
            end
            if (sum < TURN_MIN)
            begin
                sum = TURN_MIN;
                r.sat = 1'b1;
            end
            delta = sum - trk_turns;
            trk_turns = int'(sum);
            inst = clip48(round_div(delta * 1000000 * 65536, it.dt));
            alpha = (cfg_alpha > ALPHA_UNITY) ? ALPHA_UNITY : cfg_alpha;
            diff = inst - trk_velocity;
            neg = diff < 0;
            mag = neg ? -diff : diff;
            // 64-bit wrap of the product is intended
            stepm = (mag * alpha + 64'd32768) >> 16;
            trk_velocity = neg ? trk_velocity - longint'(stepm)
                               : trk_velocity + longint'(stepm);
            trk_velocity = clip48(trk_velocity);
        end
        conv = scale_to_units(longint'(trk_turns) * 65536);
        r.angle = conv[47:0];
        conv = scale_to_units(trk_velocity);
        r.velocity = conv[47:0];
    endtask

    task automatic queue_item(input logic m, input logic [ANGLE_BITS-1:0] r,
                              input logic [19:0] t);
        pending_items.push_back('{m, r, t});
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_readouts.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    assign calm = (accepted_count >= 550) && (accepted_count < 700);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sender: a new item goes out only once the previous one was taken
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_item = pending_items.pop_front();
                mode <= next_item.mode;
                raw_angle <= next_item.raw;
                interval_us <= next_item.dt;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_count >= 400)
        begin
            out_stall <= 1'b1;
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CPR:    cfg_cpr = cfg_data[12:0];
                    CFG_INVERT: cfg_invert = cfg_data[0];
                    CFG_ALPHA:  cfg_alpha = cfg_data;
                    CFG_UNITS:  cfg_units = cfg_data[1:0];
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                track_item('{mode, raw_angle, interval_us}, predicted);
                expected_readouts.push_back(predicted);
                accepted_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_readouts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: angle %h velocity %h sat %b",
                                 angle_value, velocity_value, count_saturated);
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    if (angle_value !== want.angle || velocity_value !== want.velocity ||
                        count_saturated !== want.sat)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch at cycle %0d: angle exp %h got %h, ",
                                      "velocity exp %h got %h, sat exp %b got %b"},
                                     cycle_count, want.angle, angle_value, want.velocity,
                                     velocity_value, want.sat, count_saturated);
                    end
                end
            end
        end
        in_took <= in_valid && !in_stall;
    end

    initial
    begin
        int                    pick;
        int                    step;
        int                    stim_cpr;
        logic [ANGLE_BITS-1:0] stim_angle;
        logic [ANGLE_BITS-1:0] rnd_raw;
        logic [19:0]           rnd_dt;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // reset settings: wraps both ways, exact half steps, a fold, zero interval
        queue_item(1'b1, 12'd0, 20'd0);
        queue_item(1'b0, 12'd100, 20'd1000);
        queue_item(1'b0, 12'd4095, 20'd1);
        queue_item(1'b0, 12'd0, 20'hFFFFF);
        queue_item(1'b0, 12'd2048, 20'd500);
        queue_item(1'b0, 12'd0, 20'd500);
        queue_item(1'b0, 12'd2049, 20'd500);
        queue_item(1'b0, 12'd0, 20'd0);
        queue_item(1'b0, 12'd4000, 20'd0);
        queue_item(1'b0, 12'd3000, 20'd7);
        queue_item(1'b1, 12'd4095, 20'hFFFFF);
        queue_item(1'b0, 12'd4095, 20'd3);
        wait_drained();

        // widest revolution: rate saturates both ways, reported inverted
        write_reg(CFG_CPR, 17'd8191);
        write_reg(CFG_INVERT, 17'd1);
        write_reg(CFG_ALPHA, ALPHA_UNITY);
        write_reg(CFG_UNITS, 17'(UNITS_DEG));
        queue_item(1'b1, 12'd0, 20'd55);
        queue_item(1'b0, 12'd4095, 20'd1);
        queue_item(1'b0, 12'd0, 20'd1);
        wait_drained();

        // revolution below two, weight above unity, output clipping and inverted minimum
        write_reg(CFG_CPR, 17'd0);
        write_reg(CFG_ALPHA, 17'd131071);
        queue_item(1'b1, 12'd0, 20'd0);
        queue_item(1'b0, 12'd4095, 20'd1);
        queue_item(1'b0, 12'd0, 20'd1);
        queue_item(1'b0, 12'd1, 20'd3);
        wait_drained();

        // unknown units report zero
        write_reg(CFG_CPR, 17'd1);
        write_reg(CFG_INVERT, 17'd0);
        write_reg(CFG_ALPHA, 17'd0);
        write_reg(CFG_UNITS, 17'd3);
        queue_item(1'b0, 12'd100, 20'd50);
        queue_item(1'b0, 12'd7, 20'd9);
        wait_drained();

        write_reg(CFG_CPR, 17'(CPR_RESET));
        write_reg(CFG_ALPHA, 17'd32768);
        write_reg(CFG_UNITS, 17'(UNITS_ROT));
        queue_item(1'b0, 12'd300, 20'd1000);
        queue_item(1'b0, 12'd600, 20'd1000);
        wait_drained();

        stim_angle = 12'd600;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_CPR, 17'(cpr_picks[ph]));
            write_reg(CFG_INVERT, 17'(invert_picks[ph]));
            write_reg(CFG_ALPHA, 17'(alpha_picks[ph]));
            write_reg(CFG_UNITS, 17'(units_picks[ph]));
            stim_cpr = (cpr_picks[ph] < 2) ? 2 : cpr_picks[ph];
            for (int n = 0; n < 119; n++)
            begin
                pick = $urandom_range(0, 99);
                rnd_raw = ANGLE_BITS'($urandom());
                rnd_dt = 20'($urandom());
                if (pick < 5)
                begin
                    stim_angle = rnd_raw;
                    queue_item(1'b1, rnd_raw, rnd_dt);
                end
                else if (pick < 10)
                begin
                    // zero interval leaves the tracked angle alone
                    queue_item(1'b0, rnd_raw, 20'd0);
                end
                else if (pick < 20)
                begin
                    stim_angle = rnd_raw;
                    case ($urandom_range(0, 2))
                        0:       rnd_dt = 20'd1;
                        1:       rnd_dt = 20'hFFFFF;
                        default: ;
                    endcase
                    queue_item(1'b0, stim_angle, rnd_dt);
                end
                else if (pick < 28)
                begin
                    // steps right at the fold point
                    step = stim_cpr / 2 + int'($urandom_range(0, 2)) - 1;
                    if ($urandom_range(0, 1))
                        step = -step;
                    stim_angle = stim_angle + step[ANGLE_BITS-1:0];
                    queue_item(1'b0, stim_angle, 20'($urandom_range(1, 5000)));
                end
                else
                begin
                    step = int'($urandom_range(0, 400)) - 200;
                    stim_angle = stim_angle + step[ANGLE_BITS-1:0];
                    if ($urandom_range(0, 9) != 0)
                        rnd_dt = 20'($urandom_range(200, 20000));
                    queue_item(1'b0, stim_angle, rnd_dt);
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_readouts.size() != 0)
            error_count = error_count + expected_readouts.size();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* angle_unwrap_velocity_filter.f */
hw/rtl/auvf_pkg.sv
hw/rtl/auvf_muldiv.sv
hw/rtl/angle_unwrap_velocity_filter.sv
sim/tb_angle_unwrap_velocity_filter.sv
